>>> rtl/core/pbm_pkg.sv
`default_nettype none
package pbm_pkg;
  localparam int FRAC_BITS = 15;
  localparam int CW = FRAC_BITS + 1;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);
  localparam int SQ_STEPS = CW;
  localparam int IDX_W = 1;

  typedef enum logic [2:0] {
    MODE_MIX      = 3'd0,
    MODE_ADD      = 3'd1,
    MODE_MULTIPLY = 3'd2,
    MODE_SCREEN   = 3'd3,
    MODE_OVERLAY  = 3'd4,
    MODE_SOFT     = 3'd5,
    MODE_DIFF     = 3'd6,
    MODE_NONE     = 3'd7
  } mode_t;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_OPACITY = 1'b1;

  function automatic logic [CW-1:0] sat_one(input logic [15:0] v);
    sat_one = (v > 16'(ONE)) ? ONE : v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] fx_mul(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [2*CW-1:0] p;
    p = a * b + (2*CW)'(HALF);
    fx_mul = CW'(p >> FRAC_BITS);
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/pbm_lane.sv
`default_nettype none
// One channel: mode blend, sqrt pipeline, opacity mix.
module pbm_lane import pbm_pkg::*; (
  input  wire logic          clk,
  input  wire logic [2:0]    mode,
  input  wire logic [CW-1:0] op,
  input  wire logic          color,
  input  wire logic [CW-1:0] b_in,
  input  wire logic [CW-1:0] t_in,
  output logic [CW-1:0]      res
);
  localparam int XW = 2 * CW;
  localparam int N = SQ_STEPS;
  localparam int D = N + 1;

  // sqrt pipeline: one result bit per stage
  logic [XW-1:0] rem_r [0:N];
  logic [CW-1:0] root_r [0:N];
  logic [CW-1:0] b_r [0:N];
  logic [CW-1:0] t_r [0:N];
  logic [2:0]    m_r [0:N];
  logic          c_r [0:N];

  always_ff @(posedge clk) begin
    rem_r[0]  <= XW'(b_in) << FRAC_BITS;
    root_r[0] <= '0;
    b_r[0] <= b_in;
    t_r[0] <= t_in;
    m_r[0] <= color ? mode : 3'(MODE_MIX);
    c_r[0] <= color;
  end

  for (genvar k = 0; k < N; k++) begin : g_sq
    localparam int SH = 2 * (N - 1 - k);
    logic [XW-1:0] trial;
    logic [XW-1:0] rem_nxt;
    logic [CW-1:0] root_nxt;
    always_comb begin
      trial = ((XW'(root_r[k]) << 2) | XW'(1)) << SH;
      if (rem_r[k] >= trial) begin
        rem_nxt = rem_r[k] - trial;
        root_nxt = CW'((root_r[k] << 1) | CW'(1));
      end else begin
        rem_nxt = rem_r[k];
        root_nxt = CW'(root_r[k] << 1);
      end
    end
    always_ff @(posedge clk) begin
      rem_r[k+1] <= rem_nxt;
      root_r[k+1] <= root_nxt;
      b_r[k+1] <= b_r[k];
      t_r[k+1] <= t_r[k];
      m_r[k+1] <= m_r[k];
      c_r[k+1] <= c_r[k];
    end
  end

  // rounding: rem > root means root^2+root < v
  logic [CW-1:0] s;
  assign s = (rem_r[N] > XW'(root_r[N])) ? CW'(root_r[N] + CW'(1)) : root_r[N];

  // stage A: first products
  logic [CW-1:0] b, t;
  assign b = b_r[N];
  assign t = t_r[N];
  logic [CW-1:0] nb, nt;
  assign nb = ONE - b;
  assign nt = ONE - t;

  logic [CW-1:0] pa_r, pb_r, b1_r, t1_r;
  logic [CW:0]   sum_r;
  logic [2:0]    m1_r;
  logic          lo1_r;
  logic [CW:0]   ov_lo;
  logic [CW:0]   ov_hi;
  always_ff @(posedge clk) begin
    b1_r <= b;
    t1_r <= t;
    m1_r <= m_r[N];
    sum_r <= (CW+1)'(b) + (CW+1)'(t);
    lo1_r <= (t < HALF);
    unique case (mode_t'(m_r[N]))
      MODE_MULTIPLY: pa_r <= fx_mul(b, t);
      MODE_SCREEN:   pa_r <= fx_mul(nb, nt);
      MODE_OVERLAY:  pa_r <= (b < HALF) ? CW'(ov_lo) : CW'(ov_hi);
      MODE_SOFT:     pa_r <= (t < HALF) ? fx_mul(b, nb) : ((s > b) ? CW'(s - b) : '0);
      default:       pa_r <= '0;
    endcase
    pb_r <= (m_r[N] == MODE_OVERLAY && !(b < HALF) && ov_hi > (CW+1)'(ONE)) ? '1 : '0;
  end
  logic [2*CW+1:0] ovp_lo, ovp_hi;
  assign ovp_lo = ((2*CW+2)'(b) * (2*CW+2)'(t) << 1) + (2*CW+2)'(HALF);
  assign ovp_hi = ((2*CW+2)'(nb) * (2*CW+2)'(nt) << 1) + (2*CW+2)'(HALF);
  assign ov_lo = (CW+1)'(ovp_lo >> FRAC_BITS);
  assign ov_hi = (CW+1)'(ovp_hi >> FRAC_BITS);

  // stage B: second product and clamp -> x
  logic [CW-1:0] x;
  logic [CW-1:0] f2;
  logic [CW-1:0] sp;
  assign f2 = lo1_r ? CW'(ONE - CW'(t1_r << 1)) : CW'(CW'(t1_r << 1) - ONE);
  assign sp = fx_mul(f2, pa_r);
  always_comb begin
    unique case (mode_t'(m1_r))
      MODE_ADD:      x = (sum_r > (CW+1)'(ONE)) ? ONE : CW'(sum_r);
      MODE_MULTIPLY: x = sat_one(16'(pa_r));
      MODE_SCREEN:   x = ONE - pa_r;
      MODE_OVERLAY:  x = (b1_r < HALF) ? sat_one(16'(pa_r)) :
                         ((pb_r != '0) ? '0 : CW'(ONE - pa_r));
      MODE_SOFT: begin
        if (lo1_r) x = (sp > b1_r) ? '0 : CW'(b1_r - sp);
        else x = sat_one(16'(17'(b1_r) + 17'(sp)));
      end
      MODE_DIFF:     x = (b1_r > t1_r) ? CW'(b1_r - t1_r) : CW'(t1_r - b1_r);
      default:       x = t1_r;
    endcase
  end
  logic [CW-1:0] x2_r, b2_r;
  always_ff @(posedge clk) begin
    x2_r <= x;
    b2_r <= b1_r;
  end

  // stage C: opacity product
  logic up;
  assign up = x2_r >= b2_r;
  logic [CW-1:0] d3_r, b3_r;
  logic up3_r;
  always_ff @(posedge clk) begin
    d3_r <= fx_mul(up ? CW'(x2_r - b2_r) : CW'(b2_r - x2_r), op);
    b3_r <= b2_r;
    up3_r <= up;
  end

  // stage D: apply
  always_ff @(posedge clk) begin
    if (up3_r) res <= sat_one(16'(17'(b3_r) + 17'(d3_r)));
    else res <= (d3_r > b3_r) ? '0 : CW'(b3_r - d3_r);
  end
  logic unused;
  assign unused = ^{c_r[N], D};
endmodule
`default_nettype wire

>>> rtl/core/pixel_blend_mode_mixer.sv
`default_nettype none
// Pixel blend mode mixer.
// Input: pulse start with the base and blend RGBA words and in_pixel_last;
// busy is always low, so a word may be taken every cycle.
// Output: out_valid strobes for one cycle with out_red/green/blue/alpha and
// out_last; results come in input order. The square root pipeline of each
// lane takes one root bit per stage. Throughput is one word per cycle.
// Four lanes (three colors, alpha) run in parallel; the merge stage
// registers them with the delayed last flag and strobe.
// Config: cfg_we with cfg_index 0 sets the mode, 1 sets opacity; write only
// while idle. Reset (rst_n low, synchronous) sets mode mix, opacity 1.0 and
// clears the output strobe. The receiver cannot stall: results must be taken
// in the cycle they appear.
module pixel_blend_mode_mixer import pbm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_base_red,
  input  wire logic [15:0] in_base_green,
  input  wire logic [15:0] in_base_blue,
  input  wire logic [15:0] in_base_alpha,
  input  wire logic [15:0] in_blend_red,
  input  wire logic [15:0] in_blend_green,
  input  wire logic [15:0] in_blend_blue,
  input  wire logic [15:0] in_blend_alpha,
  input  wire logic        in_pixel_last,
  input  wire logic        cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  output logic [15:0]      out_red,
  output logic [15:0]      out_green,
  output logic [15:0]      out_blue,
  output logic [15:0]      out_alpha,
  output logic             out_last
);
  localparam int LAT = SQ_STEPS + 5;

  logic [2:0]    mode_r;
  logic [15:0]   opacity_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MIX;
      opacity_r <= 16'(ONE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode_r <= cfg_data[2:0];
        REG_OPACITY: opacity_r <= cfg_data;
        default: ;
      endcase
    end
  end
  assign busy = 1'b0;

  logic [CW-1:0] op;
  assign op = sat_one(opacity_r);

  logic [CW-1:0] lane_res [0:3];
  logic [15:0] bi [0:3];
  logic [15:0] ti [0:3];
  assign bi = '{in_base_red, in_base_green, in_base_blue, in_base_alpha};
  assign ti = '{in_blend_red, in_blend_green, in_blend_blue, in_blend_alpha};

  for (genvar l = 0; l < 4; l++) begin : g_lane
    pbm_lane u_lane (
      .clk  (clk),
      .mode (mode_r),
      .op   (op),
      .color(l != 3),
      .b_in (sat_one(bi[l])),
      .t_in (sat_one(ti[l])),
      .res  (lane_res[l])
    );
  end

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LAT-2:0], start};
    last_r <= {last_r[LAT-2:0], in_pixel_last};
  end

  // merge
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= vld_r[LAT-1];
    out_red <= 16'(lane_res[0]);
    out_green <= 16'(lane_res[1]);
    out_blue <= 16'(lane_res[2]);
    out_alpha <= 16'(lane_res[3]);
    out_last <= last_r[LAT-1];
  end
endmodule
`default_nettype wire

>>> rtl/core/pbm_checker.sv
`default_nettype none
module pbm_checker import pbm_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [15:0] out_red,
  input wire logic [15:0] out_alpha
);
  a_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy");
  a_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red <= 16'(ONE)) else $error("red range");
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha <= 16'(ONE)) else $error("alpha range");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("reset");
endmodule

bind pixel_blend_mode_mixer pbm_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy),
  .out_valid(out_valid), .out_red(out_red), .out_alpha(out_alpha)
);
`default_nettype wire
